@@ rtl/symmetric_ccs_to_csr_converter_core_macros.svh @@
// Assertion helpers used by the converter datapath.
`ifndef SYMMETRIC_CCS_TO_CSR_CONVERTER_CORE_MACROS_SVH
`define SYMMETRIC_CCS_TO_CSR_CONVERTER_CORE_MACROS_SVH
`ifndef SYNTH
// Condition must never hold outside reset.
`define SCC_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("scc2csr: forbidden condition seen");
// Same-cycle implication.
`define SCC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scc2csr: implication failed");
// Next-cycle implication.
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scc2csr: next-cycle implication failed");
`else
`define SCC_ASSERT_NEVER(label, clk, rst, cond)
`define SCC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/scc2csr_pkg.sv @@
package scc2csr_pkg;

  // Fixed field widths of the item and result beats
  localparam int OPCODE_W = 3;
  localparam int ROW_W    = 11;
  localparam int WORD_W   = 64;
  localparam int POS_W    = 14;
  localparam int STATUS_W = 2;
  localparam int RPTR_W   = 14;
  localparam int COL_W    = 11;
  localparam int TOTAL_W  = 14;

  // Opcodes; codes 6 and 7 are ignored
  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR   = 3'd0,
    OP_COLUMN  = 3'd1,
    OP_ENTRY   = 3'd2,
    OP_CONVERT = 3'd3,
    OP_RD_PTR  = 3'd4,
    OP_RD_ENT  = 3'd5
  } op_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_ROW  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_READ = 2'd3;

  // Datapath commands, one per cycle
  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_CLEAR,
    CMD_COLUMN,
    CMD_ENTRY,
    CMD_RD_PTR,
    CMD_RD_ENT,
    CMD_EMIT_PTR,
    CMD_EMIT_ENT,
    CMD_SETEND,
    CMD_SCAN_RD,
    CMD_SCAN_CHK,
    CMD_FAIL,
    CMD_INIT,
    CMD_FINISH,
    CMD_U_COL,
    CMD_U_DIAG,
    CMD_U_ENT,
    CMD_U_EWR,
    CMD_U_NEXT,
    CMD_F_CLR,
    CMD_F_CNT_RD,
    CMD_F_CNT_RF,
    CMD_F_CNT_WR,
    CMD_F_PRE_RD,
    CMD_F_PRE_WR,
    CMD_REWIND,
    CMD_F_COL,
    CMD_F_DIAG,
    CMD_F_ENT,
    CMD_F_UP,
    CMD_F_LO,
    CMD_F_NEXT
  } dp_cmd_t;

  // Loop status back to the controller
  typedef struct packed {
    logic k_lt_ent;   // entry index below entry count
    logic i_lt_n;     // column index below column count
    logic k_lt_kend;  // entry index below end of current column
    logic err_nz;     // an error code is latched
  } dp_stat_t;

endpackage

@@ rtl/symmetric_ccs_to_csr_converter_core.sv @@
// Channel  | Handshake                      | Beat
// item     | start, busy (accept on !busy)  | opcode, row_number, *_word, read_position
// result   | done (one cycle, no stall)     | status, row_pointer, column_number,
//          |                                | entry_word, entry_total
// config   | APB psel/penable/pwrite        | full_pattern at byte address 0
//
// Clear, begin column and entry beats are handled in idle without raising busy, back to back.
// Reads do one row-fill or output store access, then the result beat.
// Convert runs a row scan over all stored entries and then, in upper-only mode, a walk
// over the columns, or in full mode clear, count, prefix-sum and scatter passes,
// with one access per cycle to the single-port stores.
// Reset is synchronous; stores hold no reset values. The receiver cannot stall.
module symmetric_ccs_to_csr_converter_core #(
  parameter int MAX_DIM           = 1024,
  parameter int MAX_LOWER_ENTRIES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [scc2csr_pkg::OPCODE_W-1:0]     opcode,
  input  logic [scc2csr_pkg::ROW_W-1:0]        row_number,
  input  logic [scc2csr_pkg::WORD_W-1:0]       diagonal_word,
  input  logic [scc2csr_pkg::WORD_W-1:0]       lower_word,
  input  logic [scc2csr_pkg::WORD_W-1:0]       upper_word,
  input  logic [scc2csr_pkg::POS_W-1:0]        read_position,
  output logic                                 done,
  output logic [scc2csr_pkg::STATUS_W-1:0]     status,
  output logic [scc2csr_pkg::RPTR_W-1:0]       row_pointer,
  output logic [scc2csr_pkg::COL_W-1:0]        column_number,
  output logic [scc2csr_pkg::WORD_W-1:0]       entry_word,
  output logic [scc2csr_pkg::TOTAL_W-1:0]      entry_total,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);
  import scc2csr_pkg::*;

  logic     full_pattern;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Config register
  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {31'b0, full_pattern};

  always_ff @(posedge clk) begin
    if (rst) begin
      full_pattern <= 1'b0;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      full_pattern <= pwdata[0];
    end
  end

  scc2csr_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .full   (full_pattern),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  scc2csr_dp #(
    .MAX_DIM           (MAX_DIM),
    .MAX_LOWER_ENTRIES (MAX_LOWER_ENTRIES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .row_number    (row_number),
    .diagonal_word (diagonal_word),
    .lower_word    (lower_word),
    .upper_word    (upper_word),
    .read_position (read_position),
    .stat          (stat),
    .done          (done),
    .status        (status),
    .row_pointer   (row_pointer),
    .column_number (column_number),
    .entry_word    (entry_word),
    .entry_total   (entry_total)
  );

endmodule

@@ rtl/scc2csr_ctrl.sv @@
module scc2csr_ctrl (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [scc2csr_pkg::OPCODE_W-1:0]     opcode,
  input  logic                                 full,
  input  scc2csr_pkg::dp_stat_t                stat,
  output scc2csr_pkg::dp_cmd_t                 cmd,
  output logic                                 busy
);
  import scc2csr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_DECIDE,
    S_U_COL, S_U_DIAG, S_U_ENT, S_U_EWR,
    S_F_CLR, S_F_CNT_RD, S_F_CNT_RF, S_F_CNT_WR,
    S_F_PRE_RD, S_F_PRE_WR, S_F_COL, S_F_DIAG, S_F_ENT, S_F_UP, S_F_LO,
    S_EMIT_PTR, S_EMIT_ENT
  } state_t;

  state_t state, state_next;

  assign busy = (state != S_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (opcode)
            OP_CLEAR:   cmd = CMD_CLEAR;
            OP_COLUMN:  cmd = CMD_COLUMN;
            OP_ENTRY:   cmd = CMD_ENTRY;
            OP_CONVERT: begin
              cmd        = CMD_SETEND;
              state_next = S_SCAN_RD;
            end
            OP_RD_PTR: begin
              cmd        = CMD_RD_PTR;
              state_next = S_EMIT_PTR;
            end
            OP_RD_ENT: begin
              cmd        = CMD_RD_ENT;
              state_next = S_EMIT_ENT;
            end
            default: cmd = CMD_NOP;
          endcase
        end
      end
      // Row range check over all stored entries
      S_SCAN_RD: begin
        if (stat.k_lt_ent) begin
          cmd        = CMD_SCAN_RD;
          state_next = S_SCAN_CHK;
        end else begin
          state_next = S_DECIDE;
        end
      end
      S_SCAN_CHK: begin
        cmd        = CMD_SCAN_CHK;
        state_next = S_SCAN_RD;
      end
      S_DECIDE: begin
        if (stat.err_nz) begin
          cmd        = CMD_FAIL;
          state_next = S_IDLE;
        end else begin
          cmd        = CMD_INIT;
          state_next = full ? S_F_CLR : S_U_COL;
        end
      end
      // Upper-only walk
      S_U_COL: begin
        if (stat.i_lt_n) begin
          cmd        = CMD_U_COL;
          state_next = S_U_DIAG;
        end else begin
          cmd        = CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      S_U_DIAG: begin
        cmd        = CMD_U_DIAG;
        state_next = S_U_ENT;
      end
      S_U_ENT: begin
        if (stat.k_lt_kend) begin
          cmd        = CMD_U_ENT;
          state_next = S_U_EWR;
        end else begin
          cmd        = CMD_U_NEXT;
          state_next = S_U_COL;
        end
      end
      S_U_EWR: begin
        cmd        = CMD_U_EWR;
        state_next = S_U_ENT;
      end
      // Full pattern: clear row counts
      S_F_CLR: begin
        if (stat.i_lt_n) begin
          cmd = CMD_F_CLR;
        end else begin
          cmd        = CMD_INIT;
          state_next = S_F_CNT_RD;
        end
      end
      // Count lower entries per row
      S_F_CNT_RD: begin
        if (stat.k_lt_ent) begin
          cmd        = CMD_F_CNT_RD;
          state_next = S_F_CNT_RF;
        end else begin
          cmd        = CMD_INIT;
          state_next = S_F_PRE_RD;
        end
      end
      S_F_CNT_RF: begin
        cmd        = CMD_F_CNT_RF;
        state_next = S_F_CNT_WR;
      end
      S_F_CNT_WR: begin
        cmd        = CMD_F_CNT_WR;
        state_next = S_F_CNT_RD;
      end
      // Prefix sum of row starts
      S_F_PRE_RD: begin
        if (stat.i_lt_n) begin
          cmd        = CMD_F_PRE_RD;
          state_next = S_F_PRE_WR;
        end else begin
          cmd        = CMD_REWIND;
          state_next = S_F_COL;
        end
      end
      S_F_PRE_WR: begin
        cmd        = CMD_F_PRE_WR;
        state_next = S_F_PRE_RD;
      end
      // Scatter
      S_F_COL: begin
        if (stat.i_lt_n) begin
          cmd        = CMD_F_COL;
          state_next = S_F_DIAG;
        end else begin
          cmd        = CMD_FINISH;
          state_next = S_IDLE;
        end
      end
      S_F_DIAG: begin
        cmd        = CMD_F_DIAG;
        state_next = S_F_ENT;
      end
      S_F_ENT: begin
        if (stat.k_lt_kend) begin
          cmd        = CMD_F_ENT;
          state_next = S_F_UP;
        end else begin
          cmd        = CMD_F_NEXT;
          state_next = S_F_COL;
        end
      end
      S_F_UP: begin
        cmd        = CMD_F_UP;
        state_next = S_F_LO;
      end
      S_F_LO: begin
        cmd        = CMD_F_LO;
        state_next = S_F_ENT;
      end
      S_EMIT_PTR: begin
        cmd        = CMD_EMIT_PTR;
        state_next = S_IDLE;
      end
      S_EMIT_ENT: begin
        cmd        = CMD_EMIT_ENT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/scc2csr_dp.sv @@
module scc2csr_dp #(
  parameter int MAX_DIM           = 1024,
  parameter int MAX_LOWER_ENTRIES = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  scc2csr_pkg::dp_cmd_t                 cmd,
  input  logic [scc2csr_pkg::ROW_W-1:0]        row_number,
  input  logic [scc2csr_pkg::WORD_W-1:0]       diagonal_word,
  input  logic [scc2csr_pkg::WORD_W-1:0]       lower_word,
  input  logic [scc2csr_pkg::WORD_W-1:0]       upper_word,
  input  logic [scc2csr_pkg::POS_W-1:0]        read_position,
  output scc2csr_pkg::dp_stat_t                stat,
  output logic                                 done,
  output logic [scc2csr_pkg::STATUS_W-1:0]     status,
  output logic [scc2csr_pkg::RPTR_W-1:0]       row_pointer,
  output logic [scc2csr_pkg::COL_W-1:0]        column_number,
  output logic [scc2csr_pkg::WORD_W-1:0]       entry_word,
  output logic [scc2csr_pkg::TOTAL_W-1:0]      entry_total
);
  import scc2csr_pkg::*;
`include "symmetric_ccs_to_csr_converter_core_macros.svh"

  localparam int OUT_DEPTH = MAX_DIM + 2 * MAX_LOWER_ENTRIES;
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int DA_W      = $clog2(MAX_DIM);
  localparam int ENT_W     = $clog2(MAX_LOWER_ENTRIES + 1);
  localparam int EA_W      = (MAX_LOWER_ENTRIES > 1) ? $clog2(MAX_LOWER_ENTRIES) : 1;
  localparam int OUT_W     = $clog2(OUT_DEPTH + 1);
  localparam int OA_W      = $clog2(OUT_DEPTH);

  // Stores
  logic [ENT_W-1:0]  cs_mem   [MAX_DIM+1];
  logic [DIM_W-1:0]  rows_mem [MAX_LOWER_ENTRIES];
  logic [WORD_W-1:0] lo_mem   [MAX_LOWER_ENTRIES];
  logic [WORD_W-1:0] up_mem   [MAX_LOWER_ENTRIES];
  logic [WORD_W-1:0] dg_mem   [MAX_DIM];
  logic [OUT_W-1:0]  rf_mem   [MAX_DIM];
  logic [DIM_W-1:0]  oc_mem   [OUT_DEPTH];
  logic [WORD_W-1:0] ov_mem   [OUT_DEPTH];

  // Registered read data
  logic [ENT_W-1:0]  cs_q;
  logic [DIM_W-1:0]  rows_q;
  logic [WORD_W-1:0] lo_q, up_q, dg_q, ov_q;
  logic [OUT_W-1:0]  rf_q;
  logic [DIM_W-1:0]  oc_q;

  // Control registers
  logic [DIM_W-1:0] col_cnt;
  logic [ENT_W-1:0] ent_cnt;
  logic             conv;
  logic [1:0]       err;
  logic [OUT_W-1:0] total;

  // Walk registers
  logic [DIM_W-1:0] i;
  logic [ENT_W-1:0] k, kend;
  logic [OUT_W-1:0] run, cur;
  logic             rd_bad, rd_zero;

  // Load and read checks
  logic col_full, ent_full, bad_row, ptr_bad, ent_bad;
  assign col_full = 32'(col_cnt) >= MAX_DIM;
  assign ent_full = 32'(ent_cnt) >= MAX_LOWER_ENTRIES;
  assign bad_row  = (col_cnt == '0) || (32'(row_number) <= 32'(col_cnt)) ||
                    (32'(row_number) > MAX_DIM);
  assign ptr_bad  = !conv || (32'(read_position) > 32'(col_cnt));
  assign ent_bad  = !conv || (32'(read_position) >= 32'(total));

  assign stat.k_lt_ent  = k < ent_cnt;
  assign stat.i_lt_n    = i < col_cnt;
  assign stat.k_lt_kend = k < kend;
  assign stat.err_nz    = err != ST_OK;

  logic [DA_W-1:0] rows_m1, pos_m1, i_a;
  logic [DIM_W-1:0] i_p1;
  assign rows_m1 = DA_W'(rows_q - DIM_W'(1));
  assign pos_m1  = DA_W'(read_position - POS_W'(1));
  assign i_a     = DA_W'(i);
  assign i_p1    = i + DIM_W'(1);

  // Port controls
  logic             ld_col, ld_ent, cs_we, cs_re, ent_re, dg_re, rf_we, rf_re, ow_e, or_e;
  logic [DIM_W-1:0] cs_wa;
  logic [DA_W-1:0]  rf_wa, rf_ra;
  logic [OUT_W-1:0] rf_wd, ow_a;
  logic [DIM_W-1:0] ow_c;
  logic [WORD_W-1:0] ow_v;

  // Memory port muxing per command
  always_comb begin
    ld_col = 1'b0;
    ld_ent = 1'b0;
    cs_we  = 1'b0;
    cs_wa  = col_cnt;
    cs_re  = 1'b0;
    ent_re = 1'b0;
    dg_re  = 1'b0;
    rf_we  = 1'b0;
    rf_wa  = i_a;
    rf_wd  = run;
    rf_re  = 1'b0;
    rf_ra  = i_a;
    ow_e   = 1'b0;
    ow_a   = run;
    ow_c   = i_p1;
    ow_v   = dg_q;
    or_e   = 1'b0;
    case (cmd)
      CMD_COLUMN: begin
        ld_col = !col_full;
        cs_we  = !col_full;
      end
      CMD_ENTRY: ld_ent = !bad_row && !ent_full;
      CMD_SETEND: cs_we = 1'b1;
      CMD_RD_PTR: begin
        rf_re = 1'b1;
        rf_ra = pos_m1;
      end
      CMD_RD_ENT: or_e = 1'b1;
      CMD_SCAN_RD, CMD_U_ENT, CMD_F_CNT_RD, CMD_F_ENT: ent_re = 1'b1;
      CMD_U_COL: begin
        dg_re = 1'b1;
        cs_re = 1'b1;
      end
      CMD_U_DIAG: ow_e = 1'b1;
      CMD_U_EWR: begin
        ow_e = 1'b1;
        ow_c = rows_q;
        ow_v = lo_q;
      end
      CMD_U_NEXT: rf_we = 1'b1;
      CMD_F_CLR: begin
        rf_we = 1'b1;
        rf_wd = '0;
      end
      CMD_F_CNT_RF: begin
        rf_re = 1'b1;
        rf_ra = rows_m1;
      end
      CMD_F_CNT_WR: begin
        rf_we = 1'b1;
        rf_wa = rows_m1;
        rf_wd = rf_q + OUT_W'(1);
      end
      CMD_F_PRE_RD: begin
        rf_re = 1'b1;
        cs_re = 1'b1;
      end
      CMD_F_PRE_WR: rf_we = 1'b1;
      CMD_F_COL: begin
        rf_re = 1'b1;
        dg_re = 1'b1;
        cs_re = 1'b1;
      end
      CMD_F_DIAG: begin
        ow_e = 1'b1;
        ow_a = rf_q;
      end
      CMD_F_UP: begin
        ow_e  = 1'b1;
        ow_a  = cur;
        ow_c  = rows_q;
        ow_v  = up_q;
        rf_re = 1'b1;
        rf_ra = rows_m1;
      end
      CMD_F_LO: begin
        ow_e  = 1'b1;
        ow_a  = rf_q;
        ow_v  = lo_q;
        rf_we = 1'b1;
        rf_wa = rows_m1;
        rf_wd = rf_q + OUT_W'(1);
      end
      CMD_F_NEXT: begin
        rf_we = 1'b1;
        rf_wd = cur;
      end
      default: ;
    endcase
  end

  // Column starts and diagonal store
  always_ff @(posedge clk) begin
    if (cs_we) cs_mem[cs_wa] <= ent_cnt;
    if (cs_re) cs_q <= cs_mem[i_p1];
    if (ld_col) dg_mem[DA_W'(col_cnt)] <= diagonal_word;
    if (dg_re) dg_q <= dg_mem[i_a];
  end

  // Lower entry stores
  always_ff @(posedge clk) begin
    if (ld_ent) begin
      rows_mem[EA_W'(ent_cnt)] <= DIM_W'(row_number);
      lo_mem[EA_W'(ent_cnt)]   <= lower_word;
      up_mem[EA_W'(ent_cnt)]   <= upper_word;
    end
    if (ent_re) begin
      rows_q <= rows_mem[EA_W'(k)];
      lo_q   <= lo_mem[EA_W'(k)];
      up_q   <= up_mem[EA_W'(k)];
    end
  end

  // Row fill / row end store
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (rf_re) rf_q <= rf_mem[rf_ra];
  end

  // Output entry store
  always_ff @(posedge clk) begin
    if (ow_e) begin
      oc_mem[OA_W'(ow_a)] <= ow_c;
      ov_mem[OA_W'(ow_a)] <= ow_v;
    end
    if (or_e) begin
      oc_q <= oc_mem[OA_W'(read_position)];
      ov_q <= ov_mem[OA_W'(read_position)];
    end
  end

  // Control state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      ent_cnt <= '0;
      conv    <= 1'b0;
      err     <= ST_OK;
      total   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (cmd)
        CMD_CLEAR: begin
          col_cnt <= '0;
          ent_cnt <= '0;
          conv    <= 1'b0;
          err     <= ST_OK;
          total   <= '0;
        end
        CMD_COLUMN: begin
          conv  <= 1'b0;
          total <= '0;
          if (col_full) begin
            if (err == ST_OK) err <= ST_OVERFLOW;
          end else begin
            col_cnt <= col_cnt + DIM_W'(1);
          end
        end
        CMD_ENTRY: begin
          conv  <= 1'b0;
          total <= '0;
          if (bad_row) begin
            if (err == ST_OK) err <= ST_BAD_ROW;
          end else if (ent_full) begin
            if (err == ST_OK) err <= ST_OVERFLOW;
          end else begin
            ent_cnt <= ent_cnt + ENT_W'(1);
          end
        end
        CMD_SETEND: begin
          conv  <= 1'b0;
          total <= '0;
        end
        CMD_SCAN_CHK: begin
          if (rows_q > col_cnt && err == ST_OK) err <= ST_BAD_ROW;
        end
        CMD_FINISH: begin
          conv  <= 1'b1;
          total <= run;
          done  <= 1'b1;
        end
        CMD_FAIL, CMD_EMIT_PTR, CMD_EMIT_ENT: done <= 1'b1;
        default: ;
      endcase
    end
  end

  // Walk counters and result fields
  always_ff @(posedge clk) begin
    case (cmd)
      CMD_SETEND: k <= '0;
      CMD_SCAN_RD, CMD_F_CNT_WR, CMD_U_EWR, CMD_F_LO: k <= k + ENT_W'(1);
      CMD_INIT: begin
        i    <= '0;
        k    <= '0;
        kend <= '0;
        run  <= '0;
      end
      CMD_REWIND: begin
        i <= '0;
        k <= '0;
      end
      CMD_RD_PTR: begin
        rd_bad  <= ptr_bad;
        rd_zero <= read_position == '0;
      end
      CMD_RD_ENT: rd_bad <= ent_bad;
      CMD_U_DIAG: begin
        run  <= run + OUT_W'(1);
        kend <= cs_q;
      end
      CMD_U_NEXT, CMD_F_CLR: i <= i + DIM_W'(1);
      CMD_F_PRE_WR: begin
        run  <= run + rf_q + OUT_W'(1) + OUT_W'(cs_q - kend);
        kend <= cs_q;
        i    <= i + DIM_W'(1);
      end
      CMD_F_DIAG: begin
        cur  <= rf_q + OUT_W'(1);
        kend <= cs_q;
      end
      CMD_F_UP: cur <= cur + OUT_W'(1);
      CMD_F_NEXT: i <= i + DIM_W'(1);
      default: ;
    endcase
    if (cmd == CMD_U_EWR) run <= run + OUT_W'(1);

    // Result beat
    case (cmd)
      CMD_FINISH: begin
        status        <= ST_OK;
        row_pointer   <= '0;
        column_number <= '0;
        entry_word    <= '0;
        entry_total   <= TOTAL_W'(run);
      end
      CMD_FAIL: begin
        status        <= err;
        row_pointer   <= '0;
        column_number <= '0;
        entry_word    <= '0;
        entry_total   <= '0;
      end
      CMD_EMIT_PTR: begin
        status        <= rd_bad ? ST_BAD_READ : ST_OK;
        row_pointer   <= rd_bad ? '0 : (rd_zero ? RPTR_W'(1) : RPTR_W'(rf_q + OUT_W'(1)));
        column_number <= '0;
        entry_word    <= '0;
        entry_total   <= conv ? TOTAL_W'(total) : '0;
      end
      CMD_EMIT_ENT: begin
        status        <= rd_bad ? ST_BAD_READ : ST_OK;
        row_pointer   <= '0;
        column_number <= rd_bad ? '0 : COL_W'(oc_q);
        entry_word    <= rd_bad ? '0 : ov_q;
        entry_total   <= conv ? TOTAL_W'(total) : '0;
      end
      default: ;
    endcase
  end

  `SCC_ASSERT_NEVER(a_col_cap, clk, rst, 32'(col_cnt) > MAX_DIM)
  `SCC_ASSERT_NEVER(a_ent_cap, clk, rst, 32'(ent_cnt) > MAX_LOWER_ENTRIES)
  `SCC_ASSERT_NEXT(a_done_gap, clk, rst, done, !done)
  `SCC_ASSERT_IMP(a_conv_clean, clk, rst, conv, err == ST_OK)

endmodule
